// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers; they compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ----- hw/rtl/i2cms_pkg.sv -----
package i2cms_pkg;

    // Command codes; also the sequencer state
    localparam logic [2:0] CMD_IDLE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;
    localparam logic [2:0] CMD_WAIT  = 3'd5;

    // Last step of each sequence, and step bounds inside read and wait
    localparam logic [5:0] START_LAST = 6'd2;
    localparam logic [5:0] STOP_LAST  = 6'd3;
    localparam logic [5:0] WRITE_LAST = 6'd47;
    localparam logic [5:0] READ_LAST  = 6'd29;
    localparam logic [5:0] READ_BITS_END = 6'd24;
    localparam logic [5:0] READ_REL_END  = 6'd26;
    localparam logic [5:0] READ_ACK_END  = 6'd28;
    localparam logic [5:0] WAIT_ACK_STEP = 6'd4;
    localparam logic [5:0] WAIT_SAMPLE   = 6'd2;
    localparam logic [5:0] WAIT_STOP_0   = 6'd5;
    localparam logic [5:0] WAIT_LAST     = 6'd8;

    // Bit phase limits
    localparam logic [2:0] WR_PH_LAST = 3'd5;
    localparam logic [2:0] RD_PH_LAST = 3'd2;

    localparam logic [7:0] MSB_MASK = 8'h80;

    typedef logic [2:0] cmd_t;

endpackage

// ----- hw/rtl/i2c_master_bit_sequencer_top.sv -----
// I2C master line sequencer. Each accepted item is one prescaler tick carrying
// the sampled SDA level and, while idle, an optional command (start, stop,
// write byte, read byte with ACK/NACK, wait for ACK). Every item yields exactly
// one result in the next cycle with the SCL/SDA levels to drive for that tick,
// busy/done flags, the received byte at the end of a read and the ACK level
// at the end of a wait-ack. Throughput is one item per clock: the step logic
// is a single pass from the sequencer registers to the result register, and
// s_ready stays high whenever the result register is empty or being taken.
// Commands arriving while a sequence runs are ignored.
`include "assert_macros.svh"

module i2c_master_bit_sequencer_top
    import i2cms_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_action,
    input  logic [7:0] s_tx_byte,
    input  logic       s_send_ack,
    input  logic       s_sda_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_scl,
    output logic       m_sda,
    output logic       m_busy_res,
    output logic       m_done_res,
    output logic [7:0] m_rx_byte,
    output logic       m_ack_level
);

    // Sequencer state
    cmd_t       cmd_reg,    cmd_next;
    logic [5:0] step_reg,   step_next;
    logic [2:0] ph_reg,     ph_next;
    logic [7:0] tx_reg,     tx_next;
    logic [7:0] rx_reg,     rx_next;
    logic       scl_reg,    scl_next;
    logic       sda_reg,    sda_next;
    logic       acks_reg,   acks_next;
    logic       ackc_reg,   ackc_next;

    // Result register
    logic       valid_reg,  valid_next;
    logic       oscl_reg,   oscl_next;
    logic       osda_reg,   osda_next;
    logic       obusy_reg,  obusy_next;
    logic       odone_reg,  odone_next;
    logic [7:0] orx_reg,    orx_next;
    logic       oack_reg,   oack_next;

    // Working values for this tick
    logic       accept;
    logic       starting;
    logic       active;
    cmd_t       cmd;
    logic [5:0] s;
    logic [2:0] ph;
    logic [7:0] tx;
    logic [7:0] rx;
    logic       ackc;
    logic       acks;
    logic       c, d, endc, endd, last, ackbit;
    logic [5:0] ws;

    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Command launch and effective state
    always_comb begin
        starting = (cmd_reg == CMD_IDLE) && (s_action inside {[CMD_START:CMD_WAIT]});
        cmd      = starting ? s_action : cmd_reg;
        active   = (cmd != CMD_IDLE);
        s        = starting ? 6'd0 : step_reg;
        ph       = starting ? 3'd0 : ph_reg;
        tx       = starting ? s_tx_byte : tx_reg;
        ackc     = starting ? s_send_ack : ackc_reg;
        rx       = (starting && (s_action == CMD_READ)) ? 8'd0 : rx_reg;
        ackbit   = !ackc;
        ws       = s - WAIT_STOP_0;
    end

    // Line levels for the current step
    always_comb begin
        c     = scl_reg;
        d     = sda_reg;
        endc  = 1'b0;
        endd  = 1'b0;
        last  = 1'b0;
        rx_next = rx;
        tx_next = tx;
        acks    = acks_reg;
        ph_next = 3'd0;
        case (cmd)
            CMD_START: begin
                c    = (s < 6'd2);
                d    = (s == 6'd0);
                last = (s >= START_LAST);
            end
            CMD_STOP: begin
                c    = (s[1:0] >= 2'd1);
                d    = (s[1:0] >= 2'd2);
                last = (s >= STOP_LAST);
                endc = 1'b1;
                endd = 1'b1;
            end
            CMD_WRITE: begin
                d    = |(tx & MSB_MASK);
                c    = (ph == 3'd2) || (ph == 3'd3);
                endd = d;
                last = (s >= WRITE_LAST);
                ph_next = (ph == WR_PH_LAST) ? 3'd0 : ph + 3'd1;
                if (ph == WR_PH_LAST) begin
                    tx_next = {tx[6:0], 1'b0};
                end
            end
            CMD_READ: begin
                if (s < READ_BITS_END) begin
                    d = 1'b1;
                    c = (ph == RD_PH_LAST);
                    if (ph == RD_PH_LAST) begin
                        rx_next = {rx[6:0], s_sda_in};
                    end
                end else if (s < READ_REL_END) begin
                    c = 1'b0;
                    d = 1'b1;
                end else if (s < READ_ACK_END) begin
                    c = 1'b0;
                    d = ackbit;
                end else begin
                    c = 1'b1;
                    d = ackbit;
                end
                ph_next = (ph == RD_PH_LAST) ? 3'd0 : ph + 3'd1;
                last = (s >= READ_LAST);
                endd = ackbit;
            end
            CMD_WAIT: begin
                if (s < WAIT_STOP_0) begin
                    d = 1'b1;
                    c = (s >= 6'd1) && (s <= 6'd3);
                    if (s == WAIT_SAMPLE) begin
                        acks = s_sda_in;
                    end
                    if ((s == WAIT_ACK_STEP) && !acks) begin
                        last = 1'b1;
                        endd = 1'b1;
                    end
                end else begin
                    // NACK seen: stop sequence follows
                    c = (ws[1:0] >= 2'd1);
                    d = (ws[1:0] >= 2'd2);
                    if (s >= WAIT_LAST) begin
                        last = 1'b1;
                        endc = 1'b1;
                        endd = 1'b1;
                    end
                end
            end
            default: begin
                c = scl_reg;
                d = sda_reg;
            end
        endcase
    end

    // Next state and result
    always_comb begin
        cmd_next   = cmd_reg;
        step_next  = step_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        acks_next  = acks_reg;
        ackc_next  = ackc_reg;
        valid_next = valid_reg;
        oscl_next  = oscl_reg;
        osda_next  = osda_reg;
        obusy_next = obusy_reg;
        odone_next = odone_reg;
        orx_next   = orx_reg;
        oack_next  = oack_reg;

        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (accept) begin
            valid_next = 1'b1;
            oscl_next  = c;
            osda_next  = d;
            obusy_next = active && !last;
            odone_next = active && last;
            orx_next   = (active && last && (cmd == CMD_READ)) ? rx_next : 8'd0;
            oack_next  = active && last && (cmd == CMD_WAIT) && acks;
            if (active) begin
                ackc_next = ackc;
                acks_next = acks;
                if (last) begin
                    cmd_next  = CMD_IDLE;
                    step_next = 6'd0;
                    scl_next  = endc;
                    sda_next  = endd;
                end else begin
                    cmd_next  = cmd;
                    step_next = s + 6'd1;
                    scl_next  = c;
                    sda_next  = d;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg   <= CMD_IDLE;
            step_reg  <= 6'd0;
            ph_reg    <= 3'd0;
            tx_reg    <= 8'd0;
            rx_reg    <= 8'd0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            acks_reg  <= 1'b0;
            ackc_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            cmd_reg   <= cmd_next;
            step_reg  <= step_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            acks_reg  <= acks_next;
            ackc_reg  <= ackc_next;
            valid_reg <= valid_next;
            if (accept && active) begin
                ph_reg <= ph_next;
                tx_reg <= tx_next;
                rx_reg <= rx_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        oscl_reg  <= oscl_next;
        osda_reg  <= osda_next;
        obusy_reg <= obusy_next;
        odone_reg <= odone_next;
        orx_reg   <= orx_next;
        oack_reg  <= oack_next;
    end

    assign m_valid     = valid_reg;
    assign m_scl       = oscl_reg;
    assign m_sda       = osda_reg;
    assign m_busy_res  = obusy_reg;
    assign m_done_res  = odone_reg;
    assign m_rx_byte   = orx_reg;
    assign m_ack_level = oack_reg;

    // Checks
    `ASSERT_IMPL(a_idle_step_zero, aclk, aresetn, cmd_reg == CMD_IDLE, step_reg == 6'd0)
    `ASSERT_NEXT(a_done_goes_idle, aclk, aresetn, accept && active && last, cmd_reg == CMD_IDLE)
    `ASSERT_NEXT(a_active_flags, aclk, aresetn, accept && active, m_busy_res || m_done_res)
    `ASSERT_IMPL(a_start_len, aclk, aresetn, cmd_reg == CMD_START, step_reg < 6'd3)

endmodule
